// File: rtl/core/smvma_pkg.sv
`timescale 1ns / 1ps
package smvma_pkg;
  localparam int VectorDepth = 1024;
  localparam int AddrW = $clog2(VectorDepth);
  localparam int FracBits = 16;
  localparam int DataW = 32;

  typedef enum logic [2:0] {
    OP_LOAD_X = 3'd0,
    OP_LOAD_Y = 3'd1,
    OP_BEGIN  = 3'd2,
    OP_VALUE  = 3'd3,
    OP_READ   = 3'd4
  } opcode_t;

  localparam logic [1:0] CFG_ALPHA = 2'd0;
  localparam logic [1:0] CFG_BETA  = 2'd1;
  localparam logic [1:0] CFG_TRANS = 2'd2;

  // Commands from controller to datapath
  typedef struct packed {
    logic capture;    // latch the accepted request
    logic x_rd;       // latch the y position
    logic y_rd;       // issue the y store read
    logic mul1;       // register product of data and x
    logic acc;        // fold product into row sum
    logic mul2;       // register alpha times term
    logic y_wr;       // write y store
    logic ld_wr;      // write load result
    logic mulb;       // register beta times data
    logic rd_out;     // drive the read result
  } ctl_t;

  // Status from datapath to controller
  typedef struct packed {
    logic [2:0] op;
    logic       trans;
    logic       last;
  } sts_t;

  function automatic logic signed [DataW-1:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[DataW-1:0];
  endfunction
endpackage

// File: rtl/core/smvma_ram.sv
`timescale 1ns / 1ps
module smvma_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/core/smvma_datapath.sv
`timescale 1ns / 1ps
module smvma_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  smvma_pkg::ctl_t                   ctl,
  output smvma_pkg::sts_t                   sts,
  input  logic [2:0]                        in_opcode,
  input  logic [9:0]                        in_index,
  input  logic [9:0]                        in_first_column,
  input  logic signed [31:0]                in_data_value,
  input  logic                              in_last_in_row,
  input  logic                              cfg_valid,
  input  logic [1:0]                        cfg_index,
  input  logic [31:0]                       cfg_data,
  output logic [9:0]                        out_result_index,
  output logic signed [31:0]                out_result_value
);
  import smvma_pkg::*;

  logic signed [31:0] alpha_r, beta_r;
  logic               trans_r;
  logic [2:0]  op_r;
  logic [9:0]  idx_r;
  logic signed [31:0] data_r;
  logic        last_r;
  logic [9:0]  row_r;
  logic [10:0] col_r;
  logic signed [63:0] sum_r;
  logic signed [63:0] prod_r;
  logic signed [31:0] term_r;
  logic signed [63:0] scaled_r;
  logic [10:0] ypos_r;
  logic [31:0] x_q, y_q;
  logic        we_x, we_y;
  logic [AddrW-1:0] y_waddr;
  logic [31:0] y_wdata;
  logic [10:0] xpos, ypos;
  logic signed [31:0] x_op;
  logic signed [64:0] sum_add;
  logic signed [63:0] sum_nxt;
  logic signed [65:0] y_sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= 32'sd65536;
      beta_r  <= '0;
      trans_r <= 1'b0;
      row_r   <= '0;
      col_r   <= '0;
      sum_r   <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_ALPHA: alpha_r <= cfg_data;
          CFG_BETA:  beta_r  <= cfg_data;
          CFG_TRANS: trans_r <= cfg_data[0];
          default: ;
        endcase
      end
      if (ctl.capture && in_opcode == OP_BEGIN) begin
        row_r <= in_index;
        col_r <= {1'b0, in_first_column};
        sum_r <= '0;
      end
      // Advance the column in both modes; only normal mode owns the sum
      if (ctl.acc) begin
        if (!trans_r) sum_r <= (last_r) ? '0 : sum_nxt;
        col_r <= col_r + 11'd1;
      end
    end
  end

  // Payload capture and arithmetic stages
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      op_r   <= in_opcode;
      idx_r  <= in_index;
      data_r <= in_data_value;
      last_r <= in_last_in_row;
    end
    if (ctl.mul1) prod_r <= (data_r * x_op) >>> FracBits;
    if (ctl.mulb) scaled_r <= (beta_r * data_r) >>> FracBits;
    if (ctl.acc) term_r <= trans_r ? sat32({{2{prod_r[63]}}, prod_r})
                                   : sat32({{2{sum_nxt[63]}}, sum_nxt});
    if (ctl.mul2) scaled_r <= (alpha_r * term_r) >>> FracBits;
    if (ctl.x_rd) ypos_r <= trans_r ? col_r : {1'b0, row_r};
  end

  assign xpos = trans_r ? {1'b0, row_r} : col_r;
  assign x_op = (xpos < 11'(VectorDepth)) ? signed'(x_q) : 32'sd0;
  assign sum_add = 65'(sum_r) + 65'(prod_r);
  always_comb begin
    if (sum_add > 65'sh0_7fff_ffff_ffff_ffff) sum_nxt = 64'sh7fff_ffff_ffff_ffff;
    else if (sum_add < -65'sh0_8000_0000_0000_0000) sum_nxt = 64'sh8000_0000_0000_0000;
    else sum_nxt = sum_add[63:0];
  end
  assign y_sum = 66'(signed'(y_q)) + 66'(scaled_r);
  assign ypos = ypos_r;

  always_comb begin
    we_x = ctl.capture && in_opcode == OP_LOAD_X;
    we_y = 1'b0;
    y_waddr = idx_r[AddrW-1:0];
    y_wdata = sat32({{2{scaled_r[63]}}, scaled_r});
    if (ctl.ld_wr) we_y = 1'b1;
    if (ctl.y_wr && (trans_r || last_r)) begin
      we_y = ypos < 11'(VectorDepth);
      y_waddr = ypos[AddrW-1:0];
      y_wdata = sat32(y_sum);
    end
  end

  smvma_ram #(.Width(32), .Depth(VectorDepth)) u_x (
    .clk, .we(we_x), .waddr(in_index[AddrW-1:0]), .wdata(in_data_value),
    .raddr(xpos[AddrW-1:0]), .rdata(x_q));
  smvma_ram #(.Width(32), .Depth(VectorDepth)) u_y (
    .clk, .we(we_y), .waddr(y_waddr), .wdata(y_wdata),
    .raddr(ctl.y_rd ? ypos[AddrW-1:0] : idx_r[AddrW-1:0]), .rdata(y_q));

  assign sts.op = op_r;
  assign sts.trans = trans_r;
  assign sts.last = last_r;
  assign out_result_index = idx_r;
  assign out_result_value = ctl.rd_out ? y_q : '0;
endmodule

// File: rtl/core/smvma_ctrl.sv
`timescale 1ns / 1ps
module smvma_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  smvma_pkg::sts_t sts,
  output smvma_pkg::ctl_t ctl,
  output logic            busy,
  output logic            out_strobe
);
  import smvma_pkg::*;
  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_LDY, S_XRD, S_MUL1, S_ACC, S_MUL2, S_YRD, S_YWR, S_RD, S_OUT
  } state_t;
  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    ctl = '0;
    case (state_r)
      S_IDLE: if (start) begin
        ctl.capture = 1'b1;
        state_nxt = S_DISP;
      end
      S_DISP: begin
        case (sts.op)
          OP_LOAD_Y: begin ctl.mulb = 1'b1; state_nxt = S_LDY; end
          OP_VALUE:  state_nxt = S_MUL1;
          OP_READ:   state_nxt = S_RD;
          default:   state_nxt = S_IDLE;
        endcase
        ctl.x_rd = 1'b1;
      end
      S_LDY:  begin ctl.ld_wr = 1'b1; state_nxt = S_IDLE; end
      S_MUL1: begin ctl.mul1 = 1'b1; state_nxt = S_ACC; end
      S_ACC: begin
        ctl.acc = 1'b1;
        // Drop the y update when a normal-mode row is still open
        state_nxt = (sts.trans || sts.last) ? S_XRD : S_IDLE;
      end
      S_XRD: begin ctl.mul2 = 1'b0; state_nxt = S_MUL2; end
      S_MUL2: begin ctl.mul2 = 1'b1; ctl.y_rd = 1'b1; state_nxt = S_YWR; end
      S_YWR: begin ctl.y_wr = 1'b1; state_nxt = S_IDLE; end
      S_RD:  state_nxt = S_OUT;
      S_OUT: begin ctl.rd_out = 1'b1; state_nxt = S_IDLE; end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  assign busy = state_r != S_IDLE;
  assign out_strobe = state_r == S_OUT;
endmodule

// File: rtl/core/skyline_matrix_vector_multiply_add_core.sv
`timescale 1ns / 1ps
// Skyline matrix-vector multiply-add, y = beta*y + alpha*A*x (or A^T*x),
// Q16.16. A new request is taken when start is high and busy is low; busy
// is then high until the controller is back in idle. Load x, begin row and
// unknown opcodes pass only the dispatch state, load y adds a write state,
// read y adds a read and an output state, a row value that leaves a
// normal-mode row open adds a multiply and an accumulate state, and one
// that updates y (transposed mode, or last in row) adds x read, alpha
// multiply and y read-modify-write states too, all through stores with
// registered reads. A read-y result appears on out_ for exactly one cycle
// with out_strobe, after the dispatch and read states, and cannot be
// stalled. Configuration is taken on cfg_valid whenever the core is idle
// (cfg_ready is low while busy).
module skyline_matrix_vector_multiply_add_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_opcode,
  input  logic [9:0]         in_index,
  input  logic [9:0]         in_first_column,
  input  logic signed [31:0] in_data_value,
  input  logic               in_last_in_row,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output logic               out_strobe,
  output logic [9:0]         out_result_index,
  output logic signed [31:0] out_result_value
);
  import smvma_pkg::*;
  ctl_t ctl;
  sts_t sts;

  // Hold configuration off while a request is in flight
  assign cfg_ready = !busy;

  smvma_ctrl u_ctrl (.clk, .rst_n, .start, .sts, .ctl, .busy, .out_strobe);
  smvma_datapath u_dp (
    .clk, .rst_n, .ctl, .sts, .in_opcode, .in_index, .in_first_column,
    .in_data_value, .in_last_in_row, .cfg_valid(cfg_valid && cfg_ready), .cfg_index,
    .cfg_data, .out_result_index, .out_result_value);
endmodule

// File: rtl/core/smvma_checker.sv
`timescale 1ns / 1ps
module smvma_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_strobe
);
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("no busy after start");
  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> busy) else $error("strobe while idle");
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe) else $error("strobe repeated");
endmodule

bind skyline_matrix_vector_multiply_add_core smvma_checker u_chk (
  .clk, .rst_n, .start, .busy, .out_strobe);

// File: bench/tb_skyline_matrix_vector_multiply_add_core.sv
`timescale 1ns / 1ps
module tb_skyline_matrix_vector_multiply_add_core;
  import smvma_pkg::*;

  // Request as queued for the driver
  typedef struct {
    opcode_t             op;
    logic [9:0]          idx;
    logic [9:0]          fcol;
    logic signed [31:0]  data;
    logic                last;
  } request_t;

  typedef struct {
    logic [9:0]          idx;
    logic signed [31:0]  val;
  } y_read_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [2:0] in_opcode = '0;
  logic [9:0] in_index = '0;
  logic [9:0] in_first_column = '0;
  logic signed [31:0] in_data_value = '0;
  logic in_last_in_row = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic out_strobe;
  logic [9:0] out_result_index;
  logic signed [31:0] out_result_value;

  skyline_matrix_vector_multiply_add_core uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_opcode(in_opcode), .in_index(in_index), .in_first_column(in_first_column),
    .in_data_value(in_data_value), .in_last_in_row(in_last_in_row),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .out_strobe(out_strobe),
    .out_result_index(out_result_index), .out_result_value(out_result_value)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor state, mirrors the block
  logic signed [31:0] x_vec [VectorDepth];
  logic signed [31:0] y_vec [VectorDepth];
  bit                 y_known [VectorDepth];
  logic signed [63:0] acc_sum;
  logic [9:0]         row_ptr;
  logic [10:0]        col_ptr;
  logic signed [31:0] alpha_q;
  logic signed [31:0] beta_q;
  logic               trans_q;

  request_t pending_requests[$];
  y_read_t  expected_reads[$];
  int       mismatch_count = 0;
  int       idle_pct = 0;
  longint   cycle_count = 0;
  bit       driver_done = 1'b0;

  // Q16.16 product, floor shift
  function automatic logic signed [63:0] qmul(logic signed [31:0] a, logic signed [31:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    return p >>> FracBits;
  endfunction

  function automatic logic signed [31:0] clamp32(logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic void y_accumulate(logic [10:0] pos, logic signed [63:0] delta);
    if (pos >= VectorDepth) return;
    y_vec[pos] = clamp32(66'(y_vec[pos]) + 66'(delta));
  endfunction

  // Advance the predictor by one accepted request
  function automatic void predict_request(request_t r);
    logic signed [63:0] xv;
    logic signed [64:0] s;
    y_read_t e;
    case (r.op)
      OP_LOAD_X: x_vec[r.idx] = r.data;
      OP_LOAD_Y: y_vec[r.idx] = clamp32(66'(qmul(beta_q, r.data)));
      OP_BEGIN: begin
        row_ptr = r.idx;
        col_ptr = {1'b0, r.fcol};
        acc_sum = '0;
      end
      OP_VALUE: begin
        if (trans_q) begin
          y_accumulate(col_ptr, qmul(alpha_q, clamp32(66'(qmul(r.data, x_vec[row_ptr])))));
        end else begin
          xv = (col_ptr < VectorDepth) ? 64'(x_vec[col_ptr[9:0]]) : 64'sd0;
          s = 65'(acc_sum) + 65'(qmul(r.data, xv[31:0]));
          if (s > 65'sh0_7fff_ffff_ffff_ffff) acc_sum = 64'sh7fff_ffff_ffff_ffff;
          else if (s < -65'sh0_8000_0000_0000_0000) acc_sum = 64'sh8000_0000_0000_0000;
          else acc_sum = s[63:0];
          if (r.last) begin
            y_accumulate({1'b0, row_ptr}, qmul(alpha_q, clamp32(66'(acc_sum))));
            acc_sum = '0;
          end
        end
        col_ptr = col_ptr + 11'd1;
      end
      OP_READ: begin
        e.idx = r.idx;
        e.val = y_vec[r.idx];
        expected_reads.push_back(e);
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %s: got %0h want %0h at cycle %0d", what, got, want, cycle_count);
    mismatch_count++;
  endtask

  // Driver: present the head of the queue, drop it once accepted
  always @(posedge clk) begin
    request_t r;
    if (rst_n) begin
      if (start && !busy) begin
        predict_request(pending_requests.pop_front());
      end
      if ((!start || !busy) && pending_requests.size() > 0
          && $urandom_range(99, 0) >= idle_pct) begin
        r = pending_requests[0];
        start <= 1'b1;
        in_opcode <= r.op;
        in_index <= r.idx;
        in_first_column <= r.fcol;
        in_data_value <= r.data;
        in_last_in_row <= r.last;
      end else if (!start || !busy) begin
        start <= 1'b0;
        in_data_value <= $urandom;
      end
    end
  end

  // Monitor: every strobe must match the oldest pending read
  always @(posedge clk) begin
    y_read_t e;
    cycle_count <= cycle_count + 1;
    if (rst_n && out_strobe) begin
      if (expected_reads.size() == 0) begin
        report_mismatch("unexpected result", out_result_index, 0);
      end else begin
        e = expected_reads.pop_front();
        if (out_result_index !== e.idx) report_mismatch("index", out_result_index, e.idx);
        if (out_result_value !== e.val) report_mismatch("value", out_result_value, e.val);
      end
    end
  end

  // Register write while idle; mirror it in the predictor
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_ALPHA: alpha_q = val;
      CFG_BETA:  beta_q = val;
      CFG_TRANS: trans_q = val[0];
      default: ;
    endcase
  endtask

  // Hold until every queued request is taken and all reads have returned
  task automatic drain();
    while (pending_requests.size() > 0 || start || busy || expected_reads.size() > 0)
      @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  function automatic void queue_req(opcode_t op, int idx, int fcol, logic [31:0] d, bit last);
    request_t r;
    r.op = op; r.idx = 10'(idx); r.fcol = 10'(fcol); r.data = d; r.last = last;
    pending_requests.push_back(r);
    if (op == OP_LOAD_Y) y_known[r.idx] = 1'b1;
  endfunction

  function automatic logic [31:0] rand_val();
    case ($urandom_range(5, 0))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(131072, 0) - 65536;
      default: return $urandom;
    endcase
  endfunction

  // Load a random window of x and y, stream skyline rows over it, then read y back
  function automatic void queue_matrix_block();
    int base, len, rows, r, f, n;
    base = $urandom_range(1023 - 16, 0);
    len = $urandom_range(16, 3);
    rows = $urandom_range(4, 1);
    for (int i = 0; i < len; i++) begin
      queue_req(OP_LOAD_X, base + i, 0, rand_val(), 0);
      queue_req(OP_LOAD_Y, base + i, 0, rand_val(), 0);
    end
    for (int k = 0; k < rows; k++) begin
      r = base + $urandom_range(len - 1, 0);
      f = base + $urandom_range(len - 1, 0);
      n = $urandom_range(base + len - f, 1);
      queue_req(OP_BEGIN, r, f, $urandom, $urandom_range(1, 0));
      for (int j = 0; j < n; j++)
        queue_req(OP_VALUE, $urandom, $urandom, rand_val(), j == n - 1);
    end
    for (int i = 0; i < 3; i++)
      queue_req(OP_READ, base + $urandom_range(len - 1, 0), $urandom, $urandom, $urandom);
  endfunction

  // Noise: loads anywhere, unknown opcodes, reads of written y only
  function automatic void queue_noise();
    int p;
    case ($urandom_range(3, 0))
      0: queue_req(OP_LOAD_X, $urandom_range(1023, 0), $urandom, $urandom, $urandom);
      1: queue_req(OP_LOAD_Y, $urandom_range(1023, 0), $urandom, $urandom, $urandom);
      2: queue_req(opcode_t'($urandom_range(7, 5)), $urandom, $urandom, $urandom, $urandom);
      default: begin
        p = $urandom_range(1023, 0);
        if (y_known[p]) queue_req(OP_READ, p, 0, 0, 0);
      end
    endcase
  endfunction

  localparam int PhaseIdle [4] = '{0, 60, 0, 35};

  initial begin
    acc_sum = '0; row_ptr = '0; col_ptr = '0;
    alpha_q = 32'sd65536; beta_q = '0; trans_q = 1'b0;
    foreach (y_known[i]) y_known[i] = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: beta zero gives zero, extremes, values without a begin row,
    // continuation after a last entry, index extremes
    queue_req(OP_LOAD_X, 0, 0, 32'h7fffffff, 0);
    queue_req(OP_LOAD_X, 1, 0, 32'h80000000, 0);
    queue_req(OP_LOAD_X, 2, 0, 32'h00018000, 0);
    queue_req(OP_LOAD_X, 1023, 0, 32'h00010000, 0);
    queue_req(OP_LOAD_Y, 0, 0, 32'h12345678, 0);
    queue_req(OP_LOAD_Y, 1023, 0, 32'h7fffffff, 0);
    queue_req(OP_LOAD_Y, 1, 0, 32'h1, 0);
    queue_req(OP_READ, 0, 0, 0, 0);
    queue_req(OP_VALUE, 0, 0, 32'h7fffffff, 0);
    queue_req(OP_VALUE, 0, 0, 32'h80000000, 1);
    queue_req(OP_VALUE, 0, 0, 32'h7fffffff, 1);
    queue_req(OP_READ, 0, 0, 0, 0);
    queue_req(OP_BEGIN, 1023, 1022, 0, 0);
    queue_req(OP_LOAD_X, 1022, 0, 32'hffff0000, 0);
    queue_req(OP_VALUE, 0, 0, 32'h00020000, 0);
    queue_req(OP_VALUE, 0, 0, 32'h00030000, 1);
    queue_req(OP_READ, 1023, 0, 0, 0);
    queue_req(opcode_t'(3'd7), 1023, 1023, 32'hffffffff, 1);
    queue_req(OP_READ, 1, 0, 0, 0);
    drain();

    // Saturating gains, then a row in transposed mode running off the top
    write_reg(CFG_ALPHA, 32'h7fffffff);
    write_reg(CFG_BETA, 32'h80000000);
    write_reg(CFG_TRANS, 32'h1);
    queue_req(OP_LOAD_Y, 1022, 0, 32'h00008000, 0);
    queue_req(OP_LOAD_Y, 1023, 0, 32'hffffffff, 0);
    queue_req(OP_BEGIN, 0, 1022, 0, 0);
    for (int j = 0; j < 4; j++) queue_req(OP_VALUE, 0, 0, 32'h7fffffff, 0);
    queue_req(OP_READ, 1022, 0, 0, 0);
    queue_req(OP_READ, 1023, 0, 0, 0);
    drain();

    // Random phases: each with its own gains and mode and idle rate
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CFG_ALPHA, (ph % 3 == 0) ? 32'h00010000 : rand_val());
      write_reg(CFG_BETA, (ph == 2) ? 32'h0 : (ph % 2 ? 32'h00010000 : rand_val()));
      write_reg(CFG_TRANS, {31'b0, ph[0]});
      idle_pct = PhaseIdle[ph % 4];
      for (int n = 0; n < 120; ) begin
        if ($urandom_range(9, 0) < 8) begin
          n += 20;
          queue_matrix_block();
        end else begin
          n++;
          queue_noise();
        end
      end
      drain();
    end
    driver_done = 1'b1;
  end

  // End of run, or timeout
  initial begin
    wait (driver_done || cycle_count > 400000);
    if (!driver_done) begin
      $display("end of test: mismatches");
      $finish;
    end
    if (mismatch_count == 0 && expected_reads.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
